>>> design/wavhp_pkg.sv
// wavhp_pkg: shared types and constants for the riff wave header parser
// phase encoding, status codes, magic words and stream widths
// no dependencies
package wavhp_pkg;

	typedef enum logic [3:0] {
		PH_RIFF    = 4'd0,
		PH_FSIZE   = 4'd1,
		PH_WAVE    = 4'd2,
		PH_FMTID   = 4'd3,
		PH_FMTSIZE = 4'd4,
		PH_FMTBODY = 4'd5,
		PH_FMTSKIP = 4'd6,
		PH_CHID    = 4'd7,
		PH_CHSIZE  = 4'd8,
		PH_CHSKIP  = 4'd9,
		PH_DONE    = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_RIFF   = 3'd1,
		ST_NO_WAVE   = 3'd2,
		ST_FMT_SHORT = 3'd3,
		ST_NO_DATA   = 3'd4
	} status_t;

	localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
	localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
	localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_BODY_LEN = 32'd16;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 256;
	localparam int STATUS_W   = 3;
	localparam int CFG_ADDR_W = 3;

	// register index, taken from the word address bit
	localparam logic REG_BASE_OFFSET = 1'b0;

endpackage

>>> design/wav_header_parser_top.sv
// wav_header_parser_top: byte-stream riff wave header parser with apb config port
// one pass per byte between the input handshake and a registered result stage
// depends on wavhp_pkg
// result: m_tvalid rises in the cycle after the byte that completes it is accepted
// throughput: one byte per cycle; s_tready = !m_tvalid || m_tready, so the result register
//   is the only stall point
// reset: arst_n clears the parse phase, counters, base_offset and the result valid flag
// header fields are held in registers loaded as the bytes arrive; no memory is used
module wav_header_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wavhp_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] data_byte
	input  logic                                s_tlast,  // last_byte
	input  logic                                s_tuser,  // first_byte
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] file_size, [63:32] fmt_size, [79:64] format_tag, [95:80] channel_count,
	// [127:96] sample_rate, [159:128] byte_rate, [175:160] block_align,
	// [191:176] sample_bits, [223:192] data_size, [255:224] data_offset
	output logic [wavhp_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [wavhp_pkg::STATUS_W-1:0]      m_tuser,  // [2:0] status
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wavhp_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	// control state
	wavhp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  fbc_q, fbc_d;
	logic [31:0] asm_q, asm_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] pos_q, pos_d;
	logic        isdata_q, isdata_d;
	logic [31:0] base_q;

	// captured header fields
	logic [31:0] file_q, file_d;
	logic [31:0] fmt_q, fmt_d;
	logic [15:0] tag_q, tag_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [31:0] brate_q, brate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;

	// result stage
	logic                                m_tvalid_q;
	logic [wavhp_pkg::OUT_DATA_W-1:0]    m_tdata_q;
	logic [wavhp_pkg::STATUS_W-1:0]      m_tuser_q;

	logic acc;
	logic cfg_wr;

	// working values for the current byte (restart applied)
	wavhp_pkg::phase_t ph;
	logic [3:0]  fbc;
	logic [31:0] asmw;
	logic [31:0] asm_n;
	logic [31:0] skip;
	logic [31:0] pos;
	logic        isdata;
	logic        wdone;
	logic        res_fire;
	wavhp_pkg::status_t res_status;
	logic [31:0] dsize;
	logic [31:0] doff;
	logic [wavhp_pkg::OUT_DATA_W-1:0] res_data;

	assign s_tready = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == wavhp_pkg::REG_BASE_OFFSET);
	assign prdata = (paddr[2] == wavhp_pkg::REG_BASE_OFFSET) ? base_q : 32'd0;

	// next state for one byte
	always_comb begin
		ph     = s_tuser ? wavhp_pkg::PH_RIFF : phase_q;
		fbc    = s_tuser ? 4'd0 : fbc_q;
		asmw   = s_tuser ? 32'd0 : asm_q;
		skip   = s_tuser ? 32'd0 : skip_q;
		pos    = s_tuser ? 32'd0 : pos_q;
		isdata = s_tuser ? 1'b0 : isdata_q;

		asm_n  = {s_tdata, asmw[31:8]};
		wdone  = (fbc >= 4'd3);

		phase_d  = ph;
		fbc_d    = fbc;
		asm_d    = asmw;
		skip_d   = skip;
		pos_d    = pos;
		isdata_d = isdata;
		file_d   = file_q;
		fmt_d    = fmt_q;
		tag_d    = tag_q;
		chan_d   = chan_q;
		rate_d   = rate_q;
		brate_d  = brate_q;
		align_d  = align_q;
		bits_d   = bits_q;
		dsize    = 32'd0;
		doff     = 32'd0;

		res_fire   = 1'b0;
		res_status = wavhp_pkg::ST_OK;

		if (ph != wavhp_pkg::PH_DONE) begin
			pos_d = pos + 32'd1;
			asm_d = asm_n;

			case (ph)
				wavhp_pkg::PH_RIFF, wavhp_pkg::PH_FSIZE, wavhp_pkg::PH_WAVE,
				wavhp_pkg::PH_FMTID, wavhp_pkg::PH_FMTSIZE, wavhp_pkg::PH_CHID,
				wavhp_pkg::PH_CHSIZE: begin
					fbc_d = wdone ? 4'd0 : fbc + 4'd1;
				end
				default: begin
				end
			endcase

			case (ph)
				wavhp_pkg::PH_RIFF: begin
					if (wdone) begin
						if (asm_n == wavhp_pkg::MAGIC_RIFF) begin
							phase_d = wavhp_pkg::PH_FSIZE;
						end else begin
							res_fire   = 1'b1;
							res_status = wavhp_pkg::ST_NO_RIFF;
						end
					end
				end
				wavhp_pkg::PH_FSIZE: begin
					if (wdone) begin
						file_d  = asm_n;
						phase_d = wavhp_pkg::PH_WAVE;
					end
				end
				wavhp_pkg::PH_WAVE: begin
					if (wdone) begin
						if (asm_n == wavhp_pkg::MAGIC_WAVE) begin
							phase_d = wavhp_pkg::PH_FMTID;
						end else begin
							res_fire   = 1'b1;
							res_status = wavhp_pkg::ST_NO_WAVE;
						end
					end
				end
				wavhp_pkg::PH_FMTID: begin
					if (wdone) begin
						phase_d = wavhp_pkg::PH_FMTSIZE;
					end
				end
				wavhp_pkg::PH_FMTSIZE: begin
					if (wdone) begin
						fmt_d = asm_n;
						if (asm_n < wavhp_pkg::FMT_BODY_LEN) begin
							res_fire   = 1'b1;
							res_status = wavhp_pkg::ST_FMT_SHORT;
						end else begin
							phase_d = wavhp_pkg::PH_FMTBODY;
						end
					end
				end
				wavhp_pkg::PH_FMTBODY: begin
					// byte index within the 16-byte fmt body at which each field completes
					case (fbc)
						4'd1:  tag_d   = asm_n[31:16];
						4'd3:  chan_d  = asm_n[31:16];
						4'd7:  rate_d  = asm_n;
						4'd11: brate_d = asm_n;
						4'd13: align_d = asm_n[31:16];
						4'd15: bits_d  = asm_n[31:16];
						default: begin
						end
					endcase
					if (fbc == 4'd15) begin
						fbc_d   = 4'd0;
						skip_d  = fmt_q - wavhp_pkg::FMT_BODY_LEN;
						phase_d = (skip_d == 32'd0) ? wavhp_pkg::PH_CHID
						                            : wavhp_pkg::PH_FMTSKIP;
					end else begin
						fbc_d = fbc + 4'd1;
					end
				end
				wavhp_pkg::PH_FMTSKIP, wavhp_pkg::PH_CHSKIP: begin
					skip_d = skip - 32'd1;
					if (skip_d == 32'd0) begin
						phase_d = wavhp_pkg::PH_CHID;
					end
				end
				wavhp_pkg::PH_CHID: begin
					if (wdone) begin
						isdata_d = (asm_n == wavhp_pkg::MAGIC_DATA);
						phase_d  = wavhp_pkg::PH_CHSIZE;
					end
				end
				wavhp_pkg::PH_CHSIZE: begin
					if (wdone) begin
						if (isdata) begin
							dsize      = asm_n;
							doff       = base_q + pos_d;
							res_fire   = 1'b1;
							res_status = wavhp_pkg::ST_OK;
						end else begin
							skip_d  = asm_n;
							phase_d = (asm_n == 32'd0) ? wavhp_pkg::PH_CHID
							                           : wavhp_pkg::PH_CHSKIP;
						end
					end
				end
				default: begin
				end
			endcase

			// end of file before a result
			if (!res_fire && s_tlast) begin
				res_fire = 1'b1;
				if (phase_d == wavhp_pkg::PH_RIFF) begin
					res_status = wavhp_pkg::ST_NO_RIFF;
				end else if (phase_d == wavhp_pkg::PH_FSIZE || phase_d == wavhp_pkg::PH_WAVE) begin
					res_status = wavhp_pkg::ST_NO_WAVE;
				end else begin
					res_status = wavhp_pkg::ST_NO_DATA;
				end
			end

			if (res_fire) begin
				phase_d = wavhp_pkg::PH_DONE;
			end
		end
	end

	// result payload; error results carry zero fields
	always_comb begin
		if (res_status == wavhp_pkg::ST_OK) begin
			res_data = {doff, dsize, bits_d, align_d, brate_d, rate_d,
			            chan_d, tag_d, fmt_d, file_d};
		end else begin
			res_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wavhp_pkg::PH_RIFF;
			fbc_q      <= 4'd0;
			asm_q      <= 32'd0;
			skip_q     <= 32'd0;
			pos_q      <= 32'd0;
			isdata_q   <= 1'b0;
			base_q     <= 32'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				base_q <= pwdata;
			end
			if (acc) begin
				phase_q    <= phase_d;
				fbc_q      <= fbc_d;
				asm_q      <= asm_d;
				skip_q     <= skip_d;
				pos_q      <= pos_d;
				isdata_q   <= isdata_d;
				m_tvalid_q <= res_fire;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// header fields and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			file_q  <= file_d;
			fmt_q   <= fmt_d;
			tag_q   <= tag_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			brate_q <= brate_d;
			align_q <= align_d;
			bits_q  <= bits_d;
			if (res_fire) begin
				m_tdata_q <= res_data;
				m_tuser_q <= res_status;
			end
		end
	end

	// error results never carry field values
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != wavhp_pkg::ST_OK) |-> (m_tdata == '0))
		else $error("error result with nonzero fields");

	// a result always parks the parser
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res_fire |=> (phase_q == wavhp_pkg::PH_DONE))
		else $error("parser not parked after result");

	// once parked, bytes without restart give nothing
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (phase_q == wavhp_pkg::PH_DONE) && !s_tuser |=> !m_tvalid)
		else $error("result from parked parser");

	// word phases keep the byte counter within one word; a parked parser may hold a body index
	a_fbc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != wavhp_pkg::PH_FMTBODY) && (phase_q != wavhp_pkg::PH_DONE)
		|-> (fbc_q <= 4'd3))
		else $error("byte counter out of range outside fmt body");

endmodule

>>> tb/sv/tb_wav_header_parser_top.sv
// tb_wav_header_parser_top: self-checking bench for the riff wave header parser
// drives byte streams of whole, broken and truncated wave headers, predicts each result
// depends on wavhp_pkg and wav_header_parser_top
`timescale 1ns / 100ps

module tb_wav_header_parser_top;

	localparam int          WATCHDOG_CYCLES = 2000;
	localparam int          BYTES_PER_PHASE = 360;
	localparam logic [31:0] FMT_CHUNK_ID    = 32'h2074_6d66; // "fmt "
	localparam logic [2:0]  BASE_ADDR       = {wavhp_pkg::REG_BASE_OFFSET, 2'b00};

	typedef struct packed {
		logic [31:0] data_offset;
		logic [31:0] data_size;
		logic [15:0] sample_bits;
		logic [15:0] block_align;
		logic [31:0] byte_rate;
		logic [31:0] sample_rate;
		logic [15:0] channel_count;
		logic [15:0] format_tag;
		logic [31:0] fmt_size;
		logic [31:0] file_size;
	} hdr_fields_t;

	typedef struct packed {
		wavhp_pkg::status_t status;
		hdr_fields_t        f;
	} hdr_result_t;

	logic                             clk;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [wavhp_pkg::IN_DATA_W-1:0]  s_tdata  = '0;  // [7:0] data_byte
	logic                             s_tlast  = 1'b0; // last_byte
	logic                             s_tuser  = 1'b0; // first_byte
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [wavhp_pkg::OUT_DATA_W-1:0] m_tdata;  // file_size up to data_offset, see hdr_fields_t
	logic [wavhp_pkg::STATUS_W-1:0]   m_tuser;  // [2:0] status
	logic                             psel     = 1'b0;
	logic                             penable  = 1'b0;
	logic                             pwrite   = 1'b0;
	logic [wavhp_pkg::CFG_ADDR_W-1:0] paddr    = '0;
	logic [31:0]                      pwdata   = '0;
	logic [31:0]                      prdata;
	logic                             pready;

	// pending stream items: {first_byte, last_byte, data_byte}
	logic [9:0]  file_bytes_q[$];
	logic [7:0]  build_q[$];
	hdr_result_t hdr_due_q[$];

	// parser prediction state
	wavhp_pkg::phase_t ph;
	logic [4:0]  fcnt;
	logic [31:0] aword;
	logic [31:0] skip_left;
	logic [31:0] pos_cnt;
	logic [31:0] chunk_id;
	hdr_fields_t acc;
	logic [31:0] cfg_base = '0;

	logic        took_byte = 1'b0;
	logic        calm      = 1'b0;
	int          n_errors  = 0;
	int          n_bytes   = 0;
	int          n_queued  = 0;
	int          n_files   = 0;
	int          n_settings = 1;
	int          idle_cycles = 0;
	int          status_seen[5] = '{default: 0};
	logic [31:0] base_plan[5];

	wav_header_parser_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic clear_parse();
		ph        = wavhp_pkg::PH_RIFF;
		fcnt      = '0;
		aword     = '0;
		skip_left = '0;
		pos_cnt   = '0;
		chunk_id  = '0;
		acc       = '0;
	endtask

	// one byte of a four byte word; true once the word is complete
	function automatic logic word_step();
		if (fcnt >= 5'd3) begin
			fcnt = '0;
			return 1'b1;
		end
		fcnt = fcnt + 5'd1;
		return 1'b0;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
		logic               hit;
		wavhp_pkg::status_t st;
		hdr_result_t        res;
		hit = 1'b0;
		st  = wavhp_pkg::ST_OK;
		if (first)
			clear_parse();
		if (ph == wavhp_pkg::PH_DONE)
			return;
		pos_cnt = pos_cnt + 32'd1;
		aword   = {b, aword[31:8]};
		case (ph)
			wavhp_pkg::PH_RIFF: begin
				if (word_step()) begin
					if (aword == wavhp_pkg::MAGIC_RIFF) ph = wavhp_pkg::PH_FSIZE;
					else begin
						hit = 1'b1;
						st  = wavhp_pkg::ST_NO_RIFF;
					end
				end
			end
			wavhp_pkg::PH_FSIZE: begin
				if (word_step()) begin
					acc.file_size = aword;
					ph = wavhp_pkg::PH_WAVE;
				end
			end
			wavhp_pkg::PH_WAVE: begin
				if (word_step()) begin
					if (aword == wavhp_pkg::MAGIC_WAVE) ph = wavhp_pkg::PH_FMTID;
					else begin
						hit = 1'b1;
						st  = wavhp_pkg::ST_NO_WAVE;
					end
				end
			end
			wavhp_pkg::PH_FMTID: begin
				if (word_step())
					ph = wavhp_pkg::PH_FMTSIZE;
			end
			wavhp_pkg::PH_FMTSIZE: begin
				if (word_step()) begin
					acc.fmt_size = aword;
					if (aword < wavhp_pkg::FMT_BODY_LEN) begin
						hit = 1'b1;
						st  = wavhp_pkg::ST_FMT_SHORT;
					end else
						ph = wavhp_pkg::PH_FMTBODY;
				end
			end
			wavhp_pkg::PH_FMTBODY: begin
				// fields land in the upper bytes of the shift register
				case (fcnt)
					5'd1:  acc.format_tag    = aword[31:16];
					5'd3:  acc.channel_count = aword[31:16];
					5'd7:  acc.sample_rate   = aword;
					5'd11: acc.byte_rate     = aword;
					5'd13: acc.block_align   = aword[31:16];
					5'd15: acc.sample_bits   = aword[31:16];
					default: ;
				endcase
				if (fcnt >= 5'd15) begin
					fcnt      = '0;
					skip_left = acc.fmt_size - wavhp_pkg::FMT_BODY_LEN;
					ph        = (skip_left == 32'd0) ? wavhp_pkg::PH_CHID
					                                 : wavhp_pkg::PH_FMTSKIP;
				end else
					fcnt = fcnt + 5'd1;
			end
			wavhp_pkg::PH_FMTSKIP, wavhp_pkg::PH_CHSKIP: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0)
					ph = wavhp_pkg::PH_CHID;
			end
			wavhp_pkg::PH_CHID: begin
				if (word_step()) begin
					chunk_id = aword;
					ph = wavhp_pkg::PH_CHSIZE;
				end
			end
			wavhp_pkg::PH_CHSIZE: begin
				if (word_step()) begin
					if (chunk_id == wavhp_pkg::MAGIC_DATA) begin
						acc.data_size   = aword;
						acc.data_offset = cfg_base + pos_cnt;
						hit = 1'b1;
						st  = wavhp_pkg::ST_OK;
					end else begin
						skip_left = aword;
						ph = (skip_left == 32'd0) ? wavhp_pkg::PH_CHID
						                          : wavhp_pkg::PH_CHSKIP;
					end
				end
			end
			default: ;
		endcase
		// end of file, unless this byte already finished the header
		if (!hit && last) begin
			hit = 1'b1;
			if (ph == wavhp_pkg::PH_RIFF) st = wavhp_pkg::ST_NO_RIFF;
			else if (ph <= wavhp_pkg::PH_WAVE) st = wavhp_pkg::ST_NO_WAVE;
			else st = wavhp_pkg::ST_NO_DATA;
		end
		if (hit) begin
			res.status = st;
			res.f      = '0;
			if (st == wavhp_pkg::ST_OK)
				res.f = acc;
			hdr_due_q.push_back(res);
			ph = wavhp_pkg::PH_DONE;
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			n_errors++;
		end
	endtask

	task automatic check_header_result();
		hdr_result_t want;
		hdr_fields_t got;
		got = m_tdata;
		if (m_tuser <= wavhp_pkg::ST_NO_DATA)
			status_seen[m_tuser]++;
		if (hdr_due_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, got status %0d data %h",
				$time, m_tuser, m_tdata);
			n_errors++;
			return;
		end
		want = hdr_due_q.pop_front();
		cmp_field("status", 32'(want.status), 32'(m_tuser));
		cmp_field("file_size", want.f.file_size, got.file_size);
		cmp_field("fmt_size", want.f.fmt_size, got.fmt_size);
		cmp_field("format_tag", 32'(want.f.format_tag), 32'(got.format_tag));
		cmp_field("channel_count", 32'(want.f.channel_count), 32'(got.channel_count));
		cmp_field("sample_rate", want.f.sample_rate, got.sample_rate);
		cmp_field("byte_rate", want.f.byte_rate, got.byte_rate);
		cmp_field("block_align", 32'(want.f.block_align), 32'(got.block_align));
		cmp_field("sample_bits", 32'(want.f.sample_bits), 32'(got.sample_bits));
		cmp_field("data_size", want.f.data_size, got.data_size);
		cmp_field("data_offset", want.f.data_offset, got.data_offset);
	endtask

	// results are checked before the byte taken at the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			took_byte = s_tvalid && s_tready;
			if (m_tvalid && m_tready)
				check_header_result();
			if (took_byte) begin
				n_bytes++;
				parse_byte(s_tdata, s_tuser, s_tlast);
			end
			if (took_byte || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: watchdog, no item moved for %0d cycles", $time, idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			s_tvalid <= 1'b0;
		else if (!s_tvalid || took_byte) begin
			if (file_bytes_q.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
				s_tvalid <= 1'b1;
				{s_tuser, s_tlast, s_tdata} <= file_bytes_q.pop_front();
			end else
				s_tvalid <= 1'b0;
		end
		m_tready <= calm || ($urandom_range(99) >= 32);
	end

	task automatic add_word(input logic [31:0] v);
		build_q.push_back(v[7:0]);
		build_q.push_back(v[15:8]);
		build_q.push_back(v[23:16]);
		build_q.push_back(v[31:24]);
	endtask

	task automatic flush_build(input int cut, input logic first_on, input logic last_on);
		int i;
		for (i = 0; i < cut; i++)
			file_bytes_q.push_back({first_on && (i == 0), last_on && (i == cut - 1), build_q[i]});
		n_queued += cut;
		n_files++;
		build_q.delete();
	endtask

	task automatic queue_random_file();
		int          kind;
		int          cut;
		int          idx;
		logic [31:0] fsz;
		logic [31:0] csz;
		logic        last_on;
		kind = $urandom_range(99);
		if (kind >= 94) begin
			// line noise with stray start and end flags
			repeat ($urandom_range(1, 8)) begin
				file_bytes_q.push_back({$urandom_range(3) == 0, $urandom_range(3) == 0,
					8'($urandom)});
				n_queued++;
			end
			return;
		end
		add_word(wavhp_pkg::MAGIC_RIFF);
		add_word($urandom);
		add_word(wavhp_pkg::MAGIC_WAVE);
		add_word(($urandom_range(1) == 1) ? FMT_CHUNK_ID : 32'($urandom));
		if (kind < 6)
			fsz = $urandom_range(15);
		else if (kind < 12)
			fsz = $urandom | 32'h0100_0000; // skip runs off the end of the file
		else
			fsz = wavhp_pkg::FMT_BODY_LEN + (($urandom_range(1) == 1) ? 0 : $urandom_range(1, 6));
		add_word(fsz);
		repeat (16) build_q.push_back(8'($urandom));
		if (fsz > wavhp_pkg::FMT_BODY_LEN && fsz < 64)
			repeat (fsz - wavhp_pkg::FMT_BODY_LEN) build_q.push_back(8'($urandom));
		repeat ($urandom_range(0, 2)) begin
			csz = $urandom_range(0, 6);
			if ($urandom_range(15) == 0)
				csz = $urandom;
			add_word($urandom);
			add_word(csz);
			if (csz < 64)
				repeat (csz) build_q.push_back(8'($urandom));
		end
		add_word(wavhp_pkg::MAGIC_DATA);
		add_word($urandom);
		if (kind >= 12 && kind < 20) begin
			// spoil one byte of the riff or the wave magic
			idx = $urandom_range(3) + ((kind < 16) ? 0 : 8);
			build_q[idx] = build_q[idx] ^ 8'($urandom_range(1, 255));
		end
		if (kind >= 20 && kind < 26) begin
			idx = build_q.size() - 8;
			build_q[idx] = build_q[idx] ^ 8'($urandom_range(1, 255));
		end
		// bytes past the result are ignored until the next start
		repeat ($urandom_range(0, 3)) build_q.push_back(8'($urandom));
		cut = build_q.size();
		last_on = (kind >= 6 && kind < 12) || (kind >= 20 && kind < 26) || $urandom_range(1);
		if (kind >= 26 && kind < 42) begin
			cut = $urandom_range(1, build_q.size());
			last_on = $urandom_range(4) != 0;
		end
		flush_build(cut, $urandom_range(15) != 0, last_on);
	endtask

	task automatic set_base_offset(input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= BASE_ADDR;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_base = v;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v) begin
			$display("%0t: base_offset read back mismatch, expected %h, got %h",
				$time, v, prdata);
			n_errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		n_settings++;
	endtask

	// hold off until every queued byte is taken and every result has come back
	task automatic drain();
		while (file_bytes_q.size() != 0 || s_tvalid || hdr_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int p;
		int target;
		clear_parse();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: bad riff magic, eof inside riff, bad wave magic,
		// eof inside file size, then an ignored byte with last set
		add_word(32'h5846_4952); // "RIFX"
		flush_build(4, 1'b1, 1'b0);
		build_q.push_back(8'h52);
		flush_build(1, 1'b1, 1'b1);
		add_word(wavhp_pkg::MAGIC_RIFF);
		add_word(32'hFFFF_FFFF);
		add_word(32'h0056_4157); // "WAV" then a zero
		flush_build(12, 1'b1, 1'b0);
		add_word(wavhp_pkg::MAGIC_RIFF);
		add_word(32'h0000_0000);
		flush_build(6, 1'b1, 1'b1);
		build_q.push_back(8'hFF);
		flush_build(1, 1'b0, 1'b1);
		drain();

		base_plan[0] = 32'hFFFF_FFFF;
		base_plan[1] = 32'h0000_0000;
		base_plan[2] = $urandom;
		base_plan[3] = 32'hFFFF_FFF0;
		base_plan[4] = $urandom;
		for (p = 0; p < 5; p++) begin
			set_base_offset(base_plan[p]);
			calm = (p == 2);
			target = n_queued + BYTES_PER_PHASE;
			while (n_queued < target)
				queue_random_file();
			drain();
		end

		$display("covered %0d bytes in %0d header streams over %0d base offset settings",
			n_bytes, n_files, n_settings);
		$display("results: %0d ok, %0d no riff, %0d no wave, %0d short fmt, %0d no data",
			status_seen[wavhp_pkg::ST_OK], status_seen[wavhp_pkg::ST_NO_RIFF],
			status_seen[wavhp_pkg::ST_NO_WAVE], status_seen[wavhp_pkg::ST_FMT_SHORT],
			status_seen[wavhp_pkg::ST_NO_DATA]);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
